FILE: rtl/ltd_pkg.sv
// Package for the lease task dispatcher: action and reply codes, register
// indexes, reset values, default sizes, task status type. No dependencies.
package ltd_pkg;

  localparam int DEF_MAX_MAP    = 64;
  localparam int DEF_MAX_REDUCE = 16;
  localparam int DEF_TIME_BITS  = 32;

  localparam int LEASE_W    = 16;
  localparam int MAP_CNT_W  = 7;
  localparam int RED_CNT_W  = 5;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int TASK_IX_W  = 6;
  localparam int ACTION_W   = 2;
  localparam int REPLY_W    = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEASE     = 2'd2;

  localparam logic [MAP_CNT_W-1:0] RST_MAP_COUNT = 7'd8;
  localparam logic [RED_CNT_W-1:0] RST_RED_COUNT = 5'd10;
  localparam logic [LEASE_W-1:0]   RST_LEASE     = 16'd10;

  // actions
  localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REQUEST  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_MAP_DONE = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_RED_DONE = 2'd3;

  // replies
  localparam logic [REPLY_W-1:0] REPLY_NONE   = 3'd0;
  localparam logic [REPLY_W-1:0] REPLY_MAP    = 3'd1;
  localparam logic [REPLY_W-1:0] REPLY_REDUCE = 3'd2;
  localparam logic [REPLY_W-1:0] REPLY_WAIT   = 3'd3;
  localparam logic [REPLY_W-1:0] REPLY_ALL    = 3'd4;

  // status bits of one task as seen by the lease checker
  typedef struct packed {
    logic issued;
    logic done;
  } task_status_t;

endpackage

FILE: rtl/lease_task_dispatcher.sv
// Lease task dispatcher top level: sequencer, task status bits, issue-time
// memory and output register. Depends on ltd_pkg and ltd_lease_cmp.
//
// Usage:
//  Input channel s_axis_*: tuser carries the action (tick, request, map done,
//  reduce done), tdata carries the reported task index. Output channel
//  m_axis_*: one reply item per input item, tuser is the reply kind, tdata
//  holds the assigned index and the two completion flags.
//  Configuration: cfg_wr_en/cfg_index/cfg_data write the map count, reduce
//  count and lease length; write only while the block is idle.
//  Timing: one item at a time. Every item runs a flag pass over L status
//  entries, L = max(map count in use, reduce count in use), one status entry
//  a cycle. A request then scans its phase's tasks through the read port of
//  the issue-time memory and the single lease checker, one task a cycle
//  via a registered read, stopping at the first free task or at the end
//  of the N tasks of the phase. The output register is loaded last.
//  Reset clears all status bits, the tick counter and the output valid flag;
//  issue times need no clearing since they matter only for issued tasks.
//  The output register holds a reply while the receiver stalls; the next item
//  is accepted meanwhile and waits in the last step until the register frees.
module lease_task_dispatcher import ltd_pkg::*; #(
  parameter int MAX_MAP    = DEF_MAX_MAP,
  parameter int MAX_REDUCE = DEF_MAX_REDUCE,
  parameter int TIME_BITS  = DEF_TIME_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [5:0] task_index, [7:6] zero
  input  logic [ACTION_W-1:0]   s_axis_tuser,   // [1:0] action
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [5:0] assigned_index,
                                                // [6] maps_complete,
                                                // [7] reduces_complete
  output logic [REPLY_W-1:0]    m_axis_tuser,   // [2:0] reply_kind
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int MAX_ALL = MAX_MAP > MAX_REDUCE ? MAX_MAP : MAX_REDUCE;
  localparam int SCW     = $clog2(MAX_ALL + 1);
  localparam int MIW     = MAX_MAP > 1 ? $clog2(MAX_MAP) : 1;
  localparam int RIW     = MAX_REDUCE > 1 ? $clog2(MAX_REDUCE) : 1;
  localparam int IXW     = SCW > MAP_CNT_W ? SCW : MAP_CNT_W;
  localparam int DEPTH   = MAX_MAP + MAX_REDUCE;
  localparam int AW      = $clog2(DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FLAGS = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]            state;
  logic [MAP_CNT_W-1:0]  map_task_count;
  logic [RED_CNT_W-1:0]  reduce_task_count;
  logic [LEASE_W-1:0]    lease_ticks;
  logic [TIME_BITS-1:0]  tick_count;
  logic [MAX_MAP-1:0]    map_done;
  logic [MAX_MAP-1:0]    map_issued;
  logic [MAX_REDUCE-1:0] reduce_done;
  logic [MAX_REDUCE-1:0] reduce_issued;

  logic [ACTION_W-1:0]   act;
  logic [SCW-1:0]        scan_i;    // flag pass index, also request read pointer
  logic                  mflag;
  logic                  rflag;
  logic                  phase;     // 0 map, 1 reduce
  logic                  bv;
  logic [SCW-1:0]        bi;
  logic [REPLY_W-1:0]    res_kind;
  logic [TASK_IX_W-1:0]  res_idx;

  logic [TIME_BITS-1:0]  mem [DEPTH];
  logic [TIME_BITS-1:0]  rd_data;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic                  rd_en;

  logic [SCW-1:0]        nm_use;
  logic [SCW-1:0]        nr_use;
  logic [SCW-1:0]        lim;
  logic [SCW-1:0]        n_scan;
  logic                  m_ok;
  logic                  r_ok;
  task_status_t          cur_status;
  logic                  free;
  logic                  hit;
  logic                  in_acc;
  logic                  out_load;
  logic [IXW-1:0]        tix;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign tix           = IXW'(s_axis_tdata[TASK_IX_W-1:0]);

  always_comb begin
    if (IXW'(map_task_count) > IXW'(MAX_MAP)) nm_use = SCW'(MAX_MAP);
    else nm_use = SCW'(map_task_count);
    if (IXW'(reduce_task_count) > IXW'(MAX_REDUCE)) nr_use = SCW'(MAX_REDUCE);
    else nr_use = SCW'(reduce_task_count);
    lim    = (nm_use > nr_use) ? nm_use : nr_use;
    n_scan = phase ? nr_use : nm_use;
    // entries beyond the count in use count as complete
    m_ok   = (scan_i >= nm_use) || map_done[scan_i[MIW-1:0]];
    r_ok   = (scan_i >= nr_use) || reduce_done[scan_i[RIW-1:0]];
    if (phase) begin
      cur_status.issued = reduce_issued[bi[RIW-1:0]];
      cur_status.done   = reduce_done[bi[RIW-1:0]];
    end else begin
      cur_status.issued = map_issued[bi[MIW-1:0]];
      cur_status.done   = map_done[bi[MIW-1:0]];
    end
    rd_en    = (state == S_SCAN) && (scan_i < n_scan);
    rd_addr  = phase ? AW'(MAX_MAP) + AW'(scan_i) : AW'(scan_i);
    wr_addr  = phase ? AW'(MAX_MAP) + AW'(bi) : AW'(bi);
    hit      = (state == S_SCAN) && bv && free;
    out_load = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);
  end

  ltd_lease_cmp #(
    .TIME_BITS(TIME_BITS)
  ) u_lease_cmp (
    .now      (tick_count),
    .issued_at(rd_data),
    .lease    (lease_ticks),
    .status   (cur_status),
    .free     (free)
  );

  // issue-time memory: one read and one write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (hit) begin
      mem[wr_addr] <= tick_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      map_task_count    <= RST_MAP_COUNT;
      reduce_task_count <= RST_RED_COUNT;
      lease_ticks       <= RST_LEASE;
      tick_count        <= '0;
      map_done          <= '0;
      map_issued        <= '0;
      reduce_done       <= '0;
      reduce_issued     <= '0;
      m_axis_tvalid     <= 1'b0;
      act               <= ACT_TICK;
      scan_i            <= '0;
      mflag             <= 1'b0;
      rflag             <= 1'b0;
      phase             <= 1'b0;
      bv                <= 1'b0;
      bi                <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MAP_COUNT: map_task_count    <= cfg_data[MAP_CNT_W-1:0];
          CFG_RED_COUNT: reduce_task_count <= cfg_data[RED_CNT_W-1:0];
          CFG_LEASE:     lease_ticks       <= cfg_data[LEASE_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            act    <= s_axis_tuser;
            scan_i <= '0;
            mflag  <= 1'b1;
            rflag  <= 1'b1;
            case (s_axis_tuser)
              ACT_TICK: tick_count <= tick_count + 1'b1;
              ACT_MAP_DONE: begin
                if (tix < IXW'(nm_use)) map_done[tix[MIW-1:0]] <= 1'b1;
              end
              ACT_RED_DONE: begin
                if (tix < IXW'(nr_use)) reduce_done[tix[RIW-1:0]] <= 1'b1;
              end
              default: ;
            endcase
            state <= S_FLAGS;
          end
        end
        S_FLAGS: begin
          // requests leave the done bits alone, so these flags hold before
          // and after the item
          if (scan_i == lim) begin
            scan_i <= '0;
            bv     <= 1'b0;
            if (act == ACT_REQUEST) begin
              phase <= mflag;
              state <= S_SCAN;
            end else begin
              res_kind <= REPLY_NONE;
              res_idx  <= '0;
              state    <= S_DONE;
            end
          end else begin
            mflag  <= mflag && m_ok;
            rflag  <= rflag && r_ok;
            scan_i <= scan_i + 1'b1;
          end
        end
        S_SCAN: begin
          if (hit) begin
            if (phase) reduce_issued[bi[RIW-1:0]] <= 1'b1;
            else map_issued[bi[MIW-1:0]] <= 1'b1;
            res_kind <= phase ? REPLY_REDUCE : REPLY_MAP;
            res_idx  <= TASK_IX_W'(IXW'(bi));
            bv       <= 1'b0;
            state    <= S_DONE;
          end else if (rd_en) begin
            bv     <= 1'b1;
            bi     <= scan_i;
            scan_i <= scan_i + 1'b1;
          end else if (bv) begin
            bv <= 1'b0;
          end else begin
            res_kind <= (phase && rflag) ? REPLY_ALL : REPLY_WAIT;
            res_idx  <= '0;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            m_axis_tuser  <= res_kind;
            m_axis_tdata  <= {rflag, mflag, res_idx};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_map_reply_phase: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == REPLY_MAP) |-> !m_axis_tdata[6])
    else $error("map task handed out after all maps complete");

  a_reduce_reply_phase: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == REPLY_REDUCE) |->
      (m_axis_tdata[6] && !m_axis_tdata[7]))
    else $error("reduce task handed out in wrong phase");

  a_all_done_flags: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == REPLY_ALL) |->
      (m_axis_tdata[6] && m_axis_tdata[7]))
    else $error("all-done reply with incomplete tasks");

  a_flag_pass_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLAGS) |-> (scan_i <= lim))
    else $error("flag pass ran past the task limit");

  a_hit_marks_issued: assert property (@(posedge clk) disable iff (rst)
    (hit && !phase) |=> map_issued[$past(bi[MIW-1:0])])
    else $error("assigned map task not marked issued");

endmodule

FILE: rtl/ltd_lease_cmp.sv
// Lease checker: decides whether one task may be handed out now.
// Depends on ltd_pkg.
module ltd_lease_cmp import ltd_pkg::*; #(
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic [TIME_BITS-1:0] now,
  input  logic [TIME_BITS-1:0] issued_at,
  input  logic [LEASE_W-1:0]   lease,
  input  task_status_t         status,
  output logic                 free
);

  localparam int CW = TIME_BITS > LEASE_W ? TIME_BITS : LEASE_W;

  logic [TIME_BITS-1:0] age;
  logic                 expired;

  // age wraps modulo 2^TIME_BITS
  assign age     = now - issued_at;
  assign expired = CW'(age) > CW'(lease);
  assign free    = !status.done && (!status.issued || expired);

endmodule
